// ----- hdl/i2crt_pkg.sv -----
// Shared types and constants for the I2C target register file with pointer auto-increment.
// Depends on nothing; imported by i2crt_regfile and i2c_register_target_autoincrement.

package i2crt_pkg;

	localparam int BYTE_W  = 8;
	localparam int CMD_W   = 3;
	localparam int CFG_IDX_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADDR   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HWRITE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HREAD  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LWRITE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LREAD  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TAKE   = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_FAULTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_BYTE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PD_STATUS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VOUT_HIGH    = 2'd3;

	// configuration reset values
	localparam logic [BYTE_W-1:0] RST_CLEAR_FAULTS = 8'd3;
	localparam logic [BYTE_W-1:0] RST_STATUS_BYTE  = 8'd120;
	localparam logic [BYTE_W-1:0] RST_PD_STATUS    = 8'd33;
	localparam logic [BYTE_W-1:0] RST_VOUT_HIGH    = 8'd12;

	localparam logic [BYTE_W-1:0] VOUT_MASK = 8'h0F;
	localparam logic [BYTE_W-1:0] ALL_MASK  = 8'hFF;

	typedef logic [BYTE_W-1:0] byte_t;

	// one register file access: the index is always read, written when we is set
	typedef struct packed {
		logic  we;
		byte_t idx;
		byte_t wdata;
	} rf_req_t;

endpackage

// ----- hdl/i2crt_regfile.sv -----
// Register file memory with per-entry valid bits so every entry reads zero after reset.
// Depends on i2crt_pkg for rf_req_t and byte_t.

module i2crt_regfile import i2crt_pkg::*; #(
	parameter int NUM_REGS = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  rf_req_t req,
	output byte_t   rd_data
);

	localparam int AW = $clog2(NUM_REGS);

	byte_t               mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	byte_t               mem_rd_s1;
	logic                vld_rd_s1;
	logic [AW-1:0]       addr;

	assign addr = req.idx[AW-1:0];

	// write and read the storage array
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wdata;
		end
		mem_rd_s1 <= mem[addr];
	end

	// mark written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[addr] <= 1'b1;
			end
			vld_rd_s1 <= vld_q[addr];
		end
	end

	assign rd_data = vld_rd_s1 ? mem_rd_s1 : '0;

endmodule

// ----- hdl/i2c_register_target_autoincrement.sv -----
// I2C target register file: pointer capture, host access rules, local port, fault latch.
// A result strobes on done after start is taken, registered through done_s1 then done_s2.
// Throughput: one command per cycle; busy stays low. Results cannot be stalled by the
// receiver. Reset (arst_n low) clears pointer, latch, configuration to defaults and the
// valid bits, so every register reads zero.
// Depends on i2crt_pkg and i2crt_regfile.

module i2c_register_target_autoincrement import i2crt_pkg::*; #(
	parameter int NUM_REGS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     cmd,
	input  logic                 dir_read,
	input  logic [BYTE_W-1:0]    data_in,
	input  logic [BYTE_W-1:0]    local_index,
	output logic                 done,
	output logic [BYTE_W-1:0]    data_out,
	output logic                 faults_flag,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	byte_t clear_faults_addr_q;
	byte_t status_byte_addr_q;
	byte_t pd_status_addr_q;
	byte_t vout_high_addr_q;

	byte_t   ptr_q;
	logic    ptr_loaded_q;
	logic    latch_q;

	logic    accept;
	logic    host_acc;
	byte_t   idx;
	logic    in_range;
	logic    ptr_cf;
	logic    ptr_ro;
	logic    ptr_vh;
	logic    latch_nxt;
	logic    flag_nxt;
	logic    rd_live;
	rf_req_t req;
	byte_t   rd_data;

	logic    done_s1;
	logic    zero_s1;
	logic    mask_s1;
	logic    flag_s1;
	logic    done_s2;
	byte_t   data_s2;
	logic    flag_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// take configuration beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_faults_addr_q <= RST_CLEAR_FAULTS;
			status_byte_addr_q  <= RST_STATUS_BYTE;
			pd_status_addr_q    <= RST_PD_STATUS;
			vout_high_addr_q    <= RST_VOUT_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CLEAR_FAULTS: clear_faults_addr_q <= cfg_data;
				CFG_STATUS_BYTE:  status_byte_addr_q  <= cfg_data;
				CFG_PD_STATUS:    pd_status_addr_q    <= cfg_data;
				CFG_VOUT_HIGH:    vout_high_addr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode the access: host commands use the pointer, local ones the given index
	assign host_acc = (cmd == CMD_HWRITE) || (cmd == CMD_HREAD);
	assign idx      = host_acc ? ptr_q : local_index;
	assign in_range = {1'b0, idx} < (BYTE_W+1)'(NUM_REGS);
	assign ptr_cf   = ptr_q == clear_faults_addr_q;
	assign ptr_ro   = (ptr_q == status_byte_addr_q) || (ptr_q == pd_status_addr_q);
	assign ptr_vh   = ptr_q == vout_high_addr_q;

	// build the register file request
	always_comb begin
		req.idx   = idx;
		req.we    = 1'b0;
		req.wdata = data_in;
		if (accept && in_range) begin
			case (cmd)
				CMD_HWRITE: begin
					req.we    = ptr_loaded_q && !ptr_cf && !ptr_ro;
					req.wdata = ptr_vh ? (data_in & VOUT_MASK) : data_in;
				end
				CMD_LWRITE: req.we = 1'b1;
				default: ;
			endcase
		end
	end

	// next latch value and the flag this command reports
	always_comb begin
		latch_nxt = latch_q;
		case (cmd)
			CMD_HWRITE: begin
				if (!ptr_loaded_q) begin
					if (data_in == clear_faults_addr_q) latch_nxt = 1'b1;
				end else if (ptr_cf) begin
					latch_nxt = 1'b1;
				end
			end
			CMD_HREAD: if (ptr_cf) latch_nxt = 1'b1;
			CMD_TAKE:  latch_nxt = 1'b0;
			default: ;
		endcase
		flag_nxt = (cmd == CMD_TAKE) ? latch_q : latch_nxt;
	end

	// a read returns data only for an in-range host read off clear-faults or local read
	assign rd_live = in_range &&
		(((cmd == CMD_HREAD) && !ptr_cf) || (cmd == CMD_LREAD));

	// advance pointer and latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			ptr_loaded_q <= 1'b0;
			latch_q      <= 1'b0;
		end else if (accept) begin
			latch_q <= latch_nxt;
			case (cmd)
				CMD_ADDR: if (!dir_read) ptr_loaded_q <= 1'b0;
				CMD_HWRITE: begin
					if (!ptr_loaded_q) begin
						ptr_q        <= data_in;
						ptr_loaded_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				CMD_HREAD: ptr_q <= ptr_q + 1'b1;
				default: ;
			endcase
		end
	end

	i2crt_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_data(rd_data)
	);

	// stage 1 control alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= !rd_live;
		mask_s1 <= (cmd == CMD_HREAD) && ptr_vh;
		flag_s1 <= flag_nxt;
	end

	// stage 2: form the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= done_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= zero_s1 ? '0 : (rd_data & (mask_s1 ? VOUT_MASK : ALL_MASK));
		flag_s2 <= flag_s1;
	end

	assign done        = done_s2;
	assign data_out    = data_s2;
	assign faults_flag = flag_s2;

endmodule

// ----- test/i2c_register_target_autoincrement_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for i2c_register_target_autoincrement: queue-fed command driver,
// result monitor with an in-order prediction of register file, pointer and fault latch.
// Depends on i2crt_pkg and the RTL of i2c_register_target_autoincrement.

module i2c_register_target_autoincrement_tb;
	import i2crt_pkg::*;

	localparam int IDLE_LIMIT   = 500;
	localparam int SETTLE       = 6;
	localparam int PHASE_ITEMS  = 85;
	localparam int PHASES       = 7;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic             dir_read;
		byte_t            data_in;
		byte_t            local_index;
		int unsigned      gap;
	} access_t;

	typedef struct {
		byte_t data_out;
		logic  faults_flag;
	} response_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [CMD_W-1:0]     cmd = CMD_ADDR;
	logic                 dir_read = 1'b0;
	byte_t                data_in = '0;
	byte_t                local_index = '0;
	logic                 done;
	byte_t                data_out;
	logic                 faults_flag;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CLEAR_FAULTS;
	byte_t                cfg_data = '0;

	// predicted block state and configuration
	byte_t regs [256];
	byte_t ptr = '0;
	logic  ptr_loaded = 1'b0;
	logic  fault_latch = 1'b0;
	byte_t cf_addr = RST_CLEAR_FAULTS;
	byte_t status_addr = RST_STATUS_BYTE;
	byte_t pd_addr = RST_PD_STATUS;
	byte_t vout_addr = RST_VOUT_HIGH;

	access_t     access_q [$];
	response_t   response_q [$];
	access_t     held;
	int unsigned wait_cnt = 0;
	int unsigned pushed_count = 0;
	int unsigned accepted_count = 0;
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;
	logic        quiet = 1'b0;

	i2c_register_target_autoincrement u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.dir_read    (dir_read),
		.data_in     (data_in),
		.local_index (local_index),
		.done        (done),
		.data_out    (data_out),
		.faults_flag (faults_flag),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		foreach (regs[i]) regs[i] = '0;
	end

	// advance the predicted state by one command and return its result
	function automatic response_t apply_access(input access_t a);
		response_t r;
		logic      taken;
		r.data_out = '0;
		taken = 1'b0;
		case (a.cmd)
			CMD_ADDR: begin
				if (!a.dir_read) ptr_loaded = 1'b0;
			end
			CMD_HWRITE: begin
				if (!ptr_loaded) begin
					ptr = a.data_in;
					ptr_loaded = 1'b1;
					if (a.data_in == cf_addr) fault_latch = 1'b1;
				end else begin
					// clear-faults wins, then read-only status, then the masked vout byte
					if (ptr == cf_addr) begin
						fault_latch = 1'b1;
					end else if (ptr != status_addr && ptr != pd_addr) begin
						regs[ptr] = (ptr == vout_addr) ? (a.data_in & VOUT_MASK) : a.data_in;
					end
					ptr = ptr + 8'd1;
				end
			end
			CMD_HREAD: begin
				if (ptr == cf_addr) begin
					fault_latch = 1'b1;
				end else if (ptr == vout_addr) begin
					r.data_out = regs[ptr] & VOUT_MASK;
				end else begin
					r.data_out = regs[ptr];
				end
				ptr = ptr + 8'd1;
			end
			CMD_LWRITE: regs[a.local_index] = a.data_in;
			CMD_LREAD:  r.data_out = regs[a.local_index];
			CMD_TAKE: begin
				taken = fault_latch;
				fault_latch = 1'b0;
			end
			default: begin
			end
		endcase
		r.faults_flag = (a.cmd == CMD_TAKE) ? taken : fault_latch;
		return r;
	endfunction

	// driver: predict on each accepted beat, then present the next command after its gap
	always @(posedge clk or negedge arst_n) begin : drive
		access_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			wait_cnt <= 0;
		end else begin
			if (start && !busy) begin
				response_q.push_back(apply_access(held));
				accepted_count++;
			end
			if (!(start && busy)) begin
				if (access_q.size() != 0 && wait_cnt >= access_q[0].gap) begin
					nxt = access_q.pop_front();
					held = nxt;
					cmd <= nxt.cmd;
					dir_read <= nxt.dir_read;
					data_in <= nxt.data_in;
					local_index <= nxt.local_index;
					start <= 1'b1;
					wait_cnt <= 0;
				end else begin
					start <= 1'b0;
					if (access_q.size() != 0) wait_cnt <= wait_cnt + 1;
				end
			end
		end
	end

	// monitor: compare each strobed result with the oldest prediction, count idle cycles
	always @(posedge clk) begin : watch
		response_t want;
		if (arst_n) begin
			if (done) begin
				if (response_q.size() == 0) begin
					$error("result with none pending: data_out=%0h faults_flag=%0b",
						data_out, faults_flag);
					fail_count++;
				end else begin
					want = response_q.pop_front();
					if (data_out !== want.data_out) begin
						$error("data_out expected %0h actual %0h", want.data_out, data_out);
						fail_count++;
					end
					if (faults_flag !== want.faults_flag) begin
						$error("faults_flag expected %0b actual %0b",
							want.faults_flag, faults_flag);
						fail_count++;
					end
				end
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("i2c_register_target_autoincrement_tb NOT OK");
		$finish;
	end

	function automatic int unsigned next_gap();
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic byte_t rand_byte();
		return byte_t'($urandom_range(0, 255));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic add_access(input logic [CMD_W-1:0] c, input logic d, input byte_t v,
			input byte_t idx);
		access_t a;
		a.cmd = c;
		a.dir_read = d;
		a.data_in = v;
		a.local_index = idx;
		a.gap = next_gap();
		access_q.push_back(a);
		pushed_count++;
	endtask

	// favor the configured special indexes so the access rules get hit often
	function automatic byte_t pick_index();
		byte_t spot;
		case ($urandom_range(0, 5))
			0: spot = cf_addr;
			1: spot = status_addr;
			2: spot = pd_addr;
			3: spot = vout_addr;
			default: spot = rand_byte();
		endcase
		return spot;
	endfunction

	// one host transfer, a run of local accesses, a take, or noise
	task automatic add_burst();
		int unsigned kind;
		int unsigned len;
		byte_t       base;
		kind = $urandom_range(0, 9);
		len = $urandom_range(1, 6);
		base = pick_index();
		base = base - byte_t'($urandom_range(0, 2));
		if ($urandom_range(0, 3) == 0) quiet = ~quiet;
		if (kind < 4) begin
			add_access(CMD_ADDR, 1'b0, rand_byte(), rand_byte());
			add_access(CMD_HWRITE, rand_bit(), base, rand_byte());
			repeat (len)
				add_access(CMD_HWRITE, rand_bit(), rand_byte(), rand_byte());
		end else if (kind < 7) begin
			add_access(CMD_ADDR, 1'b0, rand_byte(), rand_byte());
			add_access(CMD_HWRITE, rand_bit(), base, rand_byte());
			add_access(CMD_ADDR, 1'b1, rand_byte(), rand_byte());
			repeat (len)
				add_access(CMD_HREAD, rand_bit(), rand_byte(), rand_byte());
		end else if (kind == 7) begin
			repeat (len)
				add_access(rand_bit() ? CMD_LWRITE : CMD_LREAD,
					rand_bit(), rand_byte(), pick_index());
		end else if (kind == 8) begin
			add_access(CMD_TAKE, rand_bit(), rand_byte(), rand_byte());
		end else begin
			repeat (len)
				add_access(CMD_W'($urandom_range(CMD_ADDR, CMD_TAKE)), rand_bit(),
					rand_byte(), rand_byte());
		end
	endtask

	task automatic add_segment(input int unsigned n);
		int unsigned goal;
		@(negedge clk);
		goal = pushed_count + n;
		while (pushed_count < goal) add_burst();
	endtask

	// hold the sender until every pending result has come, then let the pipe settle
	task automatic drain();
		do @(negedge clk); while (accepted_count != pushed_count || response_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CLEAR_FAULTS: cf_addr = val;
			CFG_STATUS_BYTE:  status_addr = val;
			CFG_PD_STATUS:    pd_addr = val;
			CFG_VOUT_HIGH:    vout_addr = val;
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		byte_t plan [PHASES][4];
		plan[1] = '{8'd0, 8'd0, 8'd0, 8'd0};
		plan[2] = '{8'd255, 8'd255, 8'd255, 8'd255};
		plan[3] = '{8'd0, 8'd255, 8'd1, 8'd254};
		plan[4] = '{rand_byte(), rand_byte(), rand_byte(), rand_byte()};
		plan[5] = '{rand_byte(), rand_byte(), rand_byte(), rand_byte()};
		plan[6] = '{RST_CLEAR_FAULTS, RST_STATUS_BYTE, RST_PD_STATUS, RST_VOUT_HIGH};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// local port extremes and the unmasked vout register
		add_access(CMD_LWRITE, 1'b0, 8'hA5, 8'd255);
		add_access(CMD_LREAD, 1'b1, 8'h00, 8'd255);
		add_access(CMD_LWRITE, 1'b0, 8'hFF, RST_VOUT_HIGH);
		// pointer capture, then a read transfer with the vout mask
		add_access(CMD_ADDR, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HWRITE, 1'b0, RST_VOUT_HIGH, 8'h00);
		add_access(CMD_ADDR, 1'b1, 8'hFF, 8'hFF);
		add_access(CMD_HREAD, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HREAD, 1'b1, 8'hFF, 8'hFF);
		// host write into vout keeps the low nibble
		add_access(CMD_ADDR, 1'b0, 8'hFF, 8'hFF);
		add_access(CMD_HWRITE, 1'b0, RST_VOUT_HIGH, 8'h00);
		add_access(CMD_HWRITE, 1'b0, 8'hF7, 8'h00);
		add_access(CMD_LREAD, 1'b0, 8'h00, RST_VOUT_HIGH);
		// naming clear-faults as pointer sets the latch; take clears it
		add_access(CMD_ADDR, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HWRITE, 1'b1, RST_CLEAR_FAULTS, 8'hFF);
		add_access(CMD_TAKE, 1'b0, 8'h00, 8'h00);
		add_access(CMD_TAKE, 1'b1, 8'hFF, 8'hFF);
		add_access(CMD_HWRITE, 1'b0, 8'h77, 8'h00);
		add_access(CMD_HWRITE, 1'b0, 8'h88, 8'h00);
		add_access(CMD_TAKE, 1'b0, 8'h00, 8'h00);
		// read-only status byte drops host writes
		add_access(CMD_ADDR, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HWRITE, 1'b0, RST_STATUS_BYTE, 8'h00);
		add_access(CMD_HWRITE, 1'b0, 8'h99, 8'h00);
		// pointer wrap at 255, then a host read walks into clear-faults
		add_access(CMD_ADDR, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HWRITE, 1'b0, 8'd255, 8'h00);
		add_access(CMD_HWRITE, 1'b0, 8'h81, 8'h00);
		add_access(CMD_HWRITE, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HREAD, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HREAD, 1'b0, 8'h00, 8'h00);
		add_access(CMD_HREAD, 1'b0, 8'h00, 8'h00);
		add_access(CMD_TAKE, 1'b0, 8'h00, 8'h00);

		// random traffic under each setting, with a full drain mid-phase
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				drain();
				write_cfg(CFG_CLEAR_FAULTS, plan[p][0]);
				write_cfg(CFG_STATUS_BYTE, plan[p][1]);
				write_cfg(CFG_PD_STATUS, plan[p][2]);
				write_cfg(CFG_VOUT_HIGH, plan[p][3]);
			end
			add_segment(PHASE_ITEMS);
			drain();
			add_segment(PHASE_ITEMS);
		end

		drain();
		if (fail_count == 0 && response_q.size() == 0)
			$display("i2c_register_target_autoincrement_tb OK");
		else
			$display("i2c_register_target_autoincrement_tb NOT OK");
		$finish;
	end

endmodule
